>>> hw/rtl/ssks_pkg.sv
// Shared types, codes and constants of the seek steering step unit.
package ssks_pkg;

    localparam int FRAC_BITS = 16;   // fraction bits of positions and velocities
    localparam int DT_BITS   = 16;   // fraction bits of time_step

    localparam logic [3:0] CFG_SPEED_LIMIT   = 4'd0;
    localparam logic [3:0] CFG_ACCEL_LIMIT   = 4'd1;
    localparam logic [3:0] CFG_SCREEN_WIDTH  = 4'd2;
    localparam logic [3:0] CFG_SCREEN_HEIGHT = 4'd3;

    localparam logic [11:0] RST_SPEED_LIMIT   = 12'd300;
    localparam logic [11:0] RST_ACCEL_LIMIT   = 12'd800;
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1280;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd720;

    localparam logic REQ_PLACE = 1'b0;

    localparam int REC_W = 116;      // {vel_y 30, vel_x 30, pos_y 28, pos_x 28}

    typedef enum logic [2:0] {
        R_PX, R_PY, R_VX, R_VY, R_AX, R_AY, R_DX, R_DY
    } reg_idx_t;

    typedef enum logic [1:0] {
        B_SELF, B_SLIM, B_ALIM, B_DT
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_SET, ACC_ADD
    } acc_op_t;

    typedef enum logic [3:0] {
        WR_NONE, WR_ACCEPT, WR_LOAD, WR_PLACE, WR_DIFF, WR_DV, WR_QUOT,
        WR_SHR16, WR_ADD17, WR_ADD16, WR_VEL, WR_WRAP, WR_EMIT
    } wr_op_t;

    typedef struct packed {
        wr_op_t   wr;
        reg_idx_t wr_dst;
        logic     mul_en;
        reg_idx_t mul_a;
        mul_b_t   mul_b;
        acc_op_t  acc;
        logic     sqrt_start;
        logic     div_start;
        logic     div_wrap;
        logic     div_y;
    } cmd_t;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic root_zero;
        logic root_gt_slim;
        logic root_gt_alim;
        logic id_ok;
        logic is_place;
        logic seek;
        logic out_free;
    } status_t;

endpackage

>>> hw/rtl/ssks_ram.sv
// Generic single-port-write, registered-read RAM.
module ssks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> hw/rtl/ssks_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
module ssks_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [63:0] rad_reg, rad_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [34:0] rem_sh, trial;

    always_comb begin
        rem_sh    = {rem_reg[32:0], rad_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        rem_next  = rem_reg;
        root_next = root_reg;
        rad_next  = rad_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            root_next = '0;
            rad_next  = radicand;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            rad_next = {rad_reg[61:0], 2'b00};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule

>>> hw/rtl/ssks_div.sv
// Restoring divider, one quotient bit per cycle, 30-bit quotient.
module ssks_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [59:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic [29:0] quot,
    output logic [31:0] rem
);
    logic [31:0] rem_reg, rem_next;
    logic [29:0] lo_reg, lo_next;
    logic [31:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] rem_sh;
    logic        ge;

    always_comb begin
        rem_sh    = {rem_reg, lo_reg[29]};
        ge        = rem_sh >= {1'b0, den_reg};
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            // quotient is known to fit 30 bits, so the top half is below den
            rem_next  = {2'b00, num[59:30]};
            lo_next   = num[29:0];
            den_next  = den;
            cnt_next  = 5'd30;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            lo_next  = {lo_reg[28:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = lo_reg;
    assign rem  = rem_reg;
endmodule

>>> hw/rtl/ssks_dpath.sv
// Datapath: agent table, working registers, multiplier, root and divide units.
module ssks_dpath #(
    parameter int NUM_AGENTS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ssks_pkg::cmd_t   cmd,
    output ssks_pkg::status_t status,
    input  logic [47:0]      s_tdata,
    input  logic [0:0]       s_tuser,
    input  logic             cfg_valid,
    input  logic [3:0]       cfg_index,
    input  logic [11:0]      cfg_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [119:0]     m_tdata
);
    import ssks_pkg::*;

    localparam int AW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
    localparam logic signed [32:0] VEL_MAX     = 33'sd536870911;
    localparam logic signed [31:0] OUT_VEL_MAX = 32'sd268435455;

    // configuration
    logic [11:0] speed_reg, accel_reg, width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg  <= RST_SPEED_LIMIT;
            accel_reg  <= RST_ACCEL_LIMIT;
            width_reg  <= RST_SCREEN_WIDTH;
            height_reg <= RST_SCREEN_HEIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SPEED_LIMIT:   speed_reg  <= cfg_data;
                CFG_ACCEL_LIMIT:   accel_reg  <= cfg_data;
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // scaled limits, 4095 << 16 stays below the 2^29 velocity cap
    logic [27:0] slim, alim;
    assign slim = {speed_reg, {FRAC_BITS{1'b0}}};
    assign alim = {accel_reg, {FRAC_BITS{1'b0}}};

    // request fields
    logic        req_reg, seek_reg;
    logic [3:0]  id_reg;
    logic [11:0] cx_reg, cy_reg;
    logic [15:0] dt_reg;

    // working registers
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, ax_reg, ay_reg, dx_reg, dy_reg;
    logic signed [31:0] px_next, py_next, vx_next, vy_next;
    logic signed [31:0] ax_next, ay_next, dx_next, dy_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [63:0]        acc_reg, acc_next;
    logic               div_neg_reg;
    logic [28:0]        wsize_reg;

    // agent table
    logic [NUM_AGENTS-1:0] valid_reg;
    logic [AW-1:0]         idx;
    logic [REC_W-1:0]      rd_rec, wr_rec;
    logic                  ram_we;
    logic                  id_ok;

    assign idx    = AW'(id_reg);
    assign id_ok  = 9'(id_reg) < 9'(NUM_AGENTS);
    assign wr_rec = {vy_reg[29:0], vx_reg[29:0], py_reg[27:0], px_reg[27:0]};
    assign ram_we = (cmd.wr == WR_EMIT) && id_ok;

    ssks_ram #(.WIDTH(REC_W), .DEPTH(NUM_AGENTS)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (idx),
        .wr_data (wr_rec),
        .rd_addr (idx),
        .rd_data (rd_rec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            valid_reg[idx] <= 1'b1;
        end
    end

    // operand selection
    function automatic logic signed [31:0] pick(
        reg_idx_t sel,
        logic signed [31:0] px, logic signed [31:0] py,
        logic signed [31:0] vx, logic signed [31:0] vy,
        logic signed [31:0] ax, logic signed [31:0] ay,
        logic signed [31:0] dx, logic signed [31:0] dy);
        logic signed [31:0] r;
        unique case (sel)
            R_PX: r = px;
            R_PY: r = py;
            R_VX: r = vx;
            R_VY: r = vy;
            R_AX: r = ax;
            R_AY: r = ay;
            R_DX: r = dx;
            R_DY: r = dy;
            default: r = '0;
        endcase
        return r;
    endfunction

    logic signed [31:0] mul_a, mul_b, dst_val, wrap_src;
    always_comb begin
        mul_a    = pick(cmd.mul_a, px_reg, py_reg, vx_reg, vy_reg,
                        ax_reg, ay_reg, dx_reg, dy_reg);
        dst_val  = pick(cmd.wr_dst, px_reg, py_reg, vx_reg, vy_reg,
                        ax_reg, ay_reg, dx_reg, dy_reg);
        wrap_src = cmd.div_y ? py_reg : px_reg;
        unique case (cmd.mul_b)
            B_SELF: mul_b = mul_a;
            B_SLIM: mul_b = signed'({4'b0000, slim});
            B_ALIM: mul_b = signed'({4'b0000, alim});
            B_DT:   mul_b = signed'({16'h0000, dt_reg});
            default: mul_b = '0;
        endcase
    end

    // shared root and divide units
    logic [31:0] root;
    logic        sqrt_busy, div_busy;
    logic [59:0] div_num;
    logic [31:0] div_den;
    logic [29:0] quot;
    logic [31:0] rem;
    logic [63:0] prod_mag;
    logic [31:0] src_mag;
    logic [12:0] size13;
    logic [28:0] wsize;

    always_comb begin
        prod_mag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        src_mag  = wrap_src[31] ? 32'(-wrap_src) : 32'(wrap_src);
        size13   = cmd.div_y ? {1'b0, height_reg} : {1'b0, width_reg};
        if (size13 == 13'd0) begin
            size13 = 13'd4096;       // zero size acts as 4096 pixels
        end
        wsize    = {size13, {FRAC_BITS{1'b0}}};
        div_num  = cmd.div_wrap ? 60'(src_mag) : prod_mag[59:0];
        div_den  = cmd.div_wrap ? 32'(wsize) : root;
    end

    ssks_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (acc_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    ssks_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (quot),
        .rem     (rem)
    );

    // write-back values
    logic signed [31:0] q_signed, wr_val, shr16, shr17;
    logic [28:0]        wrap_r;
    logic [27:0]        wrapped;
    logic signed [32:0] sum_x, sum_y;

    function automatic logic signed [31:0] sat_vel(logic signed [32:0] s);
        logic signed [31:0] r;
        if (s > VEL_MAX) begin
            r = 32'(VEL_MAX);
        end else if (s < -VEL_MAX) begin
            r = 32'(-VEL_MAX);
        end else begin
            r = 32'(s);
        end
        return r;
    endfunction

    always_comb begin
        q_signed = div_neg_reg ? -signed'({2'b00, quot}) : signed'({2'b00, quot});
        shr16    = 32'(prod_reg >>> DT_BITS);
        shr17    = 32'(prod_reg >>> (DT_BITS + 1));
        wrap_r   = rem[28:0];
        wrapped  = (div_neg_reg && wrap_r != '0) ? 28'(wsize_reg - wrap_r) : 28'(wrap_r);
        sum_x    = 33'(vx_reg) + 33'(ax_reg);
        sum_y    = 33'(vy_reg) + 33'(ay_reg);

        unique case (cmd.wr)
            WR_QUOT:  wr_val = q_signed;
            WR_SHR16: wr_val = shr16;
            WR_ADD17: wr_val = dst_val + shr17;
            WR_ADD16: wr_val = dst_val + shr16;
            WR_WRAP:  wr_val = signed'({4'b0000, wrapped});
            default:  wr_val = dst_val;
        endcase

        px_next = px_reg; py_next = py_reg; vx_next = vx_reg; vy_next = vy_reg;
        ax_next = ax_reg; ay_next = ay_reg; dx_next = dx_reg; dy_next = dy_reg;

        unique case (cmd.wr)
            WR_LOAD: begin
                px_next = valid_reg[idx] ? signed'({4'b0000, rd_rec[27:0]}) : '0;
                py_next = valid_reg[idx] ? signed'({4'b0000, rd_rec[55:28]}) : '0;
                vx_next = valid_reg[idx] ? 32'(signed'(rd_rec[85:56])) : '0;
                vy_next = valid_reg[idx] ? 32'(signed'(rd_rec[115:86])) : '0;
                ax_next = '0;
                ay_next = '0;
            end
            WR_PLACE: begin
                px_next = signed'({4'b0000, cx_reg, {FRAC_BITS{1'b0}}});
                py_next = signed'({4'b0000, cy_reg, {FRAC_BITS{1'b0}}});
                vx_next = '0;
                vy_next = '0;
            end
            WR_DIFF: begin
                dx_next = signed'({4'b0000, cx_reg, {FRAC_BITS{1'b0}}}) - px_reg;
                dy_next = signed'({4'b0000, cy_reg, {FRAC_BITS{1'b0}}}) - py_reg;
            end
            WR_DV: begin
                dx_next = dx_reg - vx_reg;
                dy_next = dy_reg - vy_reg;
            end
            WR_VEL: begin
                vx_next = sat_vel(sum_x);
                vy_next = sat_vel(sum_y);
            end
            WR_QUOT, WR_SHR16, WR_ADD17, WR_ADD16, WR_WRAP: begin
                unique case (cmd.wr_dst)
                    R_PX: px_next = wr_val;
                    R_PY: py_next = wr_val;
                    R_VX: vx_next = wr_val;
                    R_VY: vy_next = wr_val;
                    R_AX: ax_next = wr_val;
                    R_AY: ay_next = wr_val;
                    R_DX: dx_next = wr_val;
                    R_DY: dy_next = wr_val;
                    default: ;
                endcase
            end
            default: ;
        endcase

        prod_next = cmd.mul_en ? mul_a * mul_b : prod_reg;
        unique case (cmd.acc)
            ACC_SET: acc_next = 64'(prod_reg);
            ACC_ADD: acc_next = acc_reg + 64'(prod_reg);
            default: acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        px_reg <= px_next; py_reg <= py_next; vx_reg <= vx_next; vy_reg <= vy_next;
        ax_reg <= ax_next; ay_reg <= ay_next; dx_reg <= dx_next; dy_reg <= dy_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.div_start) begin
            div_neg_reg <= cmd.div_wrap ? wrap_src[31] : prod_reg[63];
            wsize_reg   <= wsize;
        end
        if (cmd.wr == WR_ACCEPT) begin
            req_reg  <= s_tuser[0];
            id_reg   <= s_tdata[3:0];
            cx_reg   <= s_tdata[15:4];
            cy_reg   <= s_tdata[27:16];
            seek_reg <= s_tdata[28];
            dt_reg   <= s_tdata[44:29];
        end
    end

    // result register
    logic               out_valid_reg;
    logic [119:0]       out_data_reg;
    logic signed [31:0] ovx, ovy;

    always_comb begin
        ovx = (vx_reg > OUT_VEL_MAX) ? OUT_VEL_MAX :
              ((vx_reg < -OUT_VEL_MAX) ? -OUT_VEL_MAX : vx_reg);
        ovy = (vy_reg > OUT_VEL_MAX) ? OUT_VEL_MAX :
              ((vy_reg < -OUT_VEL_MAX) ? -OUT_VEL_MAX : vy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.wr == WR_EMIT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.wr == WR_EMIT) begin
            if (id_ok) begin
                out_data_reg <= {2'b00, ovy[28:0], ovx[28:0], py_reg[27:0],
                                 px_reg[27:0], id_reg};
            end else begin
                out_data_reg <= {116'd0, id_reg};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        status.sqrt_busy    = sqrt_busy;
        status.div_busy     = div_busy;
        status.root_zero    = root == '0;
        status.root_gt_slim = root > 32'(slim);
        status.root_gt_alim = root > 32'(alim);
        status.id_ok        = id_ok;
        status.is_place     = req_reg == REQ_PLACE;
        status.seek         = seek_reg;
        status.out_free     = !out_valid_reg || m_tready;
    end
endmodule

>>> hw/rtl/ssks_ctrl.sv
// Controller: sequences one request through the shared datapath units.
module ssks_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ssks_pkg::status_t status,
    output ssks_pkg::cmd_t    cmd
);
    import ssks_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_LOAD, S_DIFF, S_DV,
        S_SQ_A, S_SQ_B, S_SQ_C, S_SQRT, S_SQRT_W,
        S_SC_A, S_SC_B, S_SC_BW, S_SC_C, S_SC_D, S_SC_DW, S_SC_E,
        S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_K7, S_K8,
        S_WX, S_WX_W, S_WX_E, S_WY, S_WY_W, S_WY_E, S_EMIT
    } state_t;

    // length passes: target direction, velocity change, speed clamp, accel clamp
    typedef enum logic [1:0] {P_DIST, P_DL, P_CLV, P_CLA} pass_t;

    state_t   state_reg, state_next;
    pass_t    pass_reg, pass_next;
    reg_idx_t pa, pb, da, db;
    mul_b_t   plim;
    logic     skip;

    always_comb begin
        unique case (pass_reg)
            P_DIST: begin pa = R_DX; pb = R_DY; plim = B_SLIM; da = R_DX; db = R_DY; end
            P_DL:   begin pa = R_DX; pb = R_DY; plim = B_ALIM; da = R_AX; db = R_AY; end
            P_CLV:  begin pa = R_VX; pb = R_VY; plim = B_SLIM; da = R_VX; db = R_VY; end
            P_CLA:  begin pa = R_AX; pb = R_AY; plim = B_ALIM; da = R_AX; db = R_AY; end
            default: begin pa = R_DX; pb = R_DY; plim = B_SLIM; da = R_DX; db = R_DY; end
        endcase
        unique case (pass_reg)
            P_DIST, P_DL: skip = status.root_zero;
            P_CLV:        skip = !status.root_gt_slim;
            default:      skip = !status.root_gt_alim;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '{wr: WR_NONE, wr_dst: R_PX, mul_en: 1'b0, mul_a: R_PX,
                       mul_b: B_SELF, acc: ACC_HOLD, sqrt_start: 1'b0,
                       div_start: 1'b0, div_wrap: 1'b0, div_y: 1'b0};
        s_tready   = state_reg == S_IDLE;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.wr     = WR_ACCEPT;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_LOAD;
            S_LOAD: begin
                priority if (!status.id_ok) begin
                    state_next = S_EMIT;
                end else if (status.is_place) begin
                    cmd.wr     = WR_PLACE;
                    state_next = S_EMIT;
                end else if (status.seek) begin
                    cmd.wr     = WR_LOAD;
                    state_next = S_DIFF;
                end else begin
                    cmd.wr     = WR_LOAD;
                    pass_next  = P_CLV;
                    state_next = S_SQ_A;
                end
            end
            S_DIFF: begin
                cmd.wr     = WR_DIFF;
                pass_next  = P_DIST;
                state_next = S_SQ_A;
            end
            S_DV: begin
                cmd.wr     = WR_DV;
                pass_next  = P_DL;
                state_next = S_SQ_A;
            end
            S_SQ_A: begin
                cmd.mul_en = 1'b1; cmd.mul_a = pa; cmd.mul_b = B_SELF;
                state_next = S_SQ_B;
            end
            S_SQ_B: begin
                cmd.mul_en = 1'b1; cmd.mul_a = pb; cmd.mul_b = B_SELF;
                cmd.acc    = ACC_SET;
                state_next = S_SQ_C;
            end
            S_SQ_C: begin
                cmd.acc    = ACC_ADD;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT_W;
            end
            S_SQRT_W: begin
                if (!status.sqrt_busy) begin
                    if (!skip) begin
                        state_next = S_SC_A;
                    end else begin
                        unique case (pass_reg)
                            P_DIST, P_DL: begin pass_next = P_CLV; state_next = S_SQ_A; end
                            P_CLV:        begin pass_next = P_CLA; state_next = S_SQ_A; end
                            default:      state_next = S_K1;
                        endcase
                    end
                end
            end
            S_SC_A: begin
                cmd.mul_en = 1'b1; cmd.mul_a = pa; cmd.mul_b = plim;
                state_next = S_SC_B;
            end
            S_SC_B: begin
                cmd.div_start = 1'b1;
                state_next    = S_SC_BW;
            end
            S_SC_BW: if (!status.div_busy) state_next = S_SC_C;
            S_SC_C: begin
                cmd.wr     = WR_QUOT; cmd.wr_dst = da;
                cmd.mul_en = 1'b1; cmd.mul_a = pb; cmd.mul_b = plim;
                state_next = S_SC_D;
            end
            S_SC_D: begin
                cmd.div_start = 1'b1;
                state_next    = S_SC_DW;
            end
            S_SC_DW: if (!status.div_busy) state_next = S_SC_E;
            S_SC_E: begin
                cmd.wr = WR_QUOT; cmd.wr_dst = db;
                unique case (pass_reg)
                    P_DIST:  state_next = S_DV;
                    P_DL:    begin pass_next = P_CLV; state_next = S_SQ_A; end
                    P_CLV:   begin pass_next = P_CLA; state_next = S_SQ_A; end
                    default: state_next = S_K1;
                endcase
            end
            S_K1: begin
                cmd.mul_en = 1'b1; cmd.mul_a = R_AX; cmd.mul_b = B_DT;
                state_next = S_K2;
            end
            S_K2: begin
                cmd.wr = WR_SHR16; cmd.wr_dst = R_AX;
                cmd.mul_en = 1'b1; cmd.mul_a = R_AY; cmd.mul_b = B_DT;
                state_next = S_K3;
            end
            S_K3: begin
                cmd.wr = WR_SHR16; cmd.wr_dst = R_AY;
                cmd.mul_en = 1'b1; cmd.mul_a = R_AX; cmd.mul_b = B_DT;
                state_next = S_K4;
            end
            S_K4: begin
                cmd.wr = WR_ADD17; cmd.wr_dst = R_PX;
                cmd.mul_en = 1'b1; cmd.mul_a = R_AY; cmd.mul_b = B_DT;
                state_next = S_K5;
            end
            S_K5: begin
                cmd.wr = WR_ADD17; cmd.wr_dst = R_PY;
                cmd.mul_en = 1'b1; cmd.mul_a = R_VX; cmd.mul_b = B_DT;
                state_next = S_K6;
            end
            S_K6: begin
                cmd.wr = WR_ADD16; cmd.wr_dst = R_PX;
                cmd.mul_en = 1'b1; cmd.mul_a = R_VY; cmd.mul_b = B_DT;
                state_next = S_K7;
            end
            S_K7: begin
                cmd.wr = WR_ADD16; cmd.wr_dst = R_PY;
                state_next = S_K8;
            end
            S_K8: begin
                cmd.wr     = WR_VEL;
                state_next = S_WX;
            end
            S_WX: begin
                cmd.div_start = 1'b1; cmd.div_wrap = 1'b1; cmd.div_y = 1'b0;
                state_next    = S_WX_W;
            end
            S_WX_W: if (!status.div_busy) state_next = S_WX_E;
            S_WX_E: begin
                cmd.wr = WR_WRAP; cmd.wr_dst = R_PX;
                state_next = S_WY;
            end
            S_WY: begin
                cmd.div_start = 1'b1; cmd.div_wrap = 1'b1; cmd.div_y = 1'b1;
                state_next    = S_WY_W;
            end
            S_WY_W: if (!status.div_busy) state_next = S_WY_E;
            S_WY_E: begin
                cmd.wr = WR_WRAP; cmd.wr_dst = R_PY;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.wr     = WR_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pass_reg  <= P_DIST;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end
endmodule

>>> hw/rtl/seek_steering_kinematics_step_unit.sv
// Seek steering step unit: Q12.16 position, Q14.16 velocity table, 2D agents.
//
// One request is in flight at a time. A place request, or any request to an
// agent index at or above NUM_AGENTS, passes only the read, load and emit
// states after accept. In a step request every vector length goes through a
// shared root unit, and every scale by limit/length and every screen wrap
// goes through a shared one-bit-per-cycle divider; a seek step with both clamps
// active runs four roots and ten divisions; a step without seek runs two
// roots and two wrap divisions, and two more divisions if the speed clamp is
// active, plus the multiply steps that integrate position and velocity over
// time_step. A finished item sits in an output register, so the next item
// is accepted while it waits. The agent table is a RAM with one valid flop per
// entry, so entries read as zero after reset without any clearing pass.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// must only be issued while the unit is idle; unknown indexes are dropped.
module seek_steering_kinematics_step_unit #(
    parameter int NUM_AGENTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] agent_id, [15:4] coord_x, [27:16] coord_y, [28] seek_on,
    // [44:29] time_step, [47:45] zero
    input  logic [47:0]  s_tdata,
    // [0] req_type
    input  logic [0:0]   s_tuser,
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] out_agent, [31:4] new_pos_x, [59:32] new_pos_y,
    // [88:60] new_vel_x, [117:89] new_vel_y, [119:118] zero
    output logic [119:0] m_tdata,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [11:0]  cfg_data
);
    import ssks_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ssks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssks_dpath #(.NUM_AGENTS(NUM_AGENTS)) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef ASSERT_OFF
    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr == WR_EMIT) |-> status.out_free)
        else $error("result loaded over an untaken result");

    // no new item while a shared unit is still working
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!status.sqrt_busy && !status.div_busy))
        else $error("input ready while a unit is busy");

    // an accepted item blocks the input for at least the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted back to back");

    // units are never restarted while busy
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sqrt_start || cmd.div_start) |-> (!status.sqrt_busy && !status.div_busy))
        else $error("unit started while busy");
`endif
endmodule

>>> tb/sv/tb_seek_steering_kinematics_step_unit.sv
// Testbench for the seek steering step unit: random and directed items checked against a predictor.
module tb_seek_steering_kinematics_step_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ssks_pkg::*;

    typedef struct {
        logic [3:0]  agent;
        logic [27:0] pos_x;
        logic [27:0] pos_y;
        logic [28:0] vel_x;
        logic [28:0] vel_y;
    } agent_state_t;

    // Predicts agent state updates and holds the expected results in order.
    class agent_table_sb;
        logic [11:0] speed_lim, accel_lim, scr_w, scr_h;
        longint pos_x [16];
        longint pos_y [16];
        longint vel_x [16];
        longint vel_y [16];
        agent_state_t pending [$];
        int errors;

        function new();
            speed_lim = RST_SPEED_LIMIT;
            accel_lim = RST_ACCEL_LIMIT;
            scr_w = RST_SCREEN_WIDTH;
            scr_h = RST_SCREEN_HEIGHT;
            errors = 0;
            for (int i = 0; i < 16; i++) begin
                pos_x[i] = 0; pos_y[i] = 0; vel_x[i] = 0; vel_y[i] = 0;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic [3:0] idx, logic [11:0] val);
            case (idx)
                CFG_SPEED_LIMIT:   speed_lim = val;
                CFG_ACCEL_LIMIT:   accel_lim = val;
                CFG_SCREEN_WIDTH:  scr_w = val;
                CFG_SCREEN_HEIGHT: scr_h = val;
                default: ;
            endcase
        endfunction

        function longint root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function longint magnitude(longint x, longint y);
            return root_floor(longint'(x * x) + longint'(y * y));
        endfunction

        function void clamp_to(ref longint x, ref longint y, input longint lim);
            longint len;
            len = magnitude(x, y);
            if (len > lim) begin
                x = x * lim / len;
                y = y * lim / len;
            end
        endfunction

        function longint wrap_pos(longint p, logic [11:0] size);
            longint s, r;
            s = longint'(size == 0 ? 4096 : size) <<< FRAC_BITS;
            r = p % s;
            if (r < 0) r += s;
            return r;
        endfunction

        function longint clip(longint x, longint m);
            return x > m ? m : (x < -m ? -m : x);
        endfunction

        // Note an accepted request and queue the state it should produce.
        function void note_request(logic req, logic [3:0] id, logic [11:0] cx, logic [11:0] cy,
                                   logic seek, logic [15:0] dt);
            longint slim, alim, px, py, vx, vy, ax, ay, dx, dy, tgt_len, dvx, dvy, dl;
            longint adx, ady, t;
            agent_state_t e;
            t = longint'(dt);
            if (req == REQ_PLACE) begin
                pos_x[id] = longint'(cx) <<< FRAC_BITS;
                pos_y[id] = longint'(cy) <<< FRAC_BITS;
                vel_x[id] = 0;
                vel_y[id] = 0;
            end else begin
                slim = longint'(speed_lim) <<< FRAC_BITS;
                alim = longint'(accel_lim) <<< FRAC_BITS;
                px = pos_x[id]; py = pos_y[id];
                vx = vel_x[id]; vy = vel_y[id];
                ax = 0; ay = 0;
                if (seek) begin
                    dx = (longint'(cx) <<< FRAC_BITS) - px;
                    dy = (longint'(cy) <<< FRAC_BITS) - py;
                    tgt_len = magnitude(dx, dy);
                    if (tgt_len != 0) begin
                        dvx = dx * slim / tgt_len - vx;
                        dvy = dy * slim / tgt_len - vy;
                        dl = magnitude(dvx, dvy);
                        if (dl != 0) begin
                            ax = dvx * alim / dl;
                            ay = dvy * alim / dl;
                        end
                    end
                end
                clamp_to(vx, vy, slim);
                clamp_to(ax, ay, alim);
                adx = (ax * t) >>> 16;
                ady = (ay * t) >>> 16;
                px += ((vx * t) >>> 16) + (((adx * t) >>> 16) >>> 1);
                py += ((vy * t) >>> 16) + (((ady * t) >>> 16) >>> 1);
                vel_x[id] = clip(vx + adx, 64'sd536870911);
                vel_y[id] = clip(vy + ady, 64'sd536870911);
                pos_x[id] = wrap_pos(px, scr_w);
                pos_y[id] = wrap_pos(py, scr_h);
            end
            e.agent = id;
            e.pos_x = pos_x[id][27:0];
            e.pos_y = pos_y[id][27:0];
            e.vel_x = 29'(clip(vel_x[id], 64'sd268435455));
            e.vel_y = 29'(clip(vel_y[id], 64'sd268435455));
            pending = {pending, e};
        endfunction

        task check_result(logic [119:0] d);
            agent_state_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", d));
                return;
            end
            e = pending.pop_front();
            if (d[3:0] !== e.agent)
                report($sformatf("out_agent %0d, want %0d", d[3:0], e.agent));
            if (d[31:4] !== e.pos_x)
                report($sformatf("agent %0d pos_x %h, want %h", e.agent, d[31:4], e.pos_x));
            if (d[59:32] !== e.pos_y)
                report($sformatf("agent %0d pos_y %h, want %h", e.agent, d[59:32], e.pos_y));
            if (d[88:60] !== e.vel_x)
                report($sformatf("agent %0d vel_x %h, want %h", e.agent, d[88:60], e.vel_x));
            if (d[117:89] !== e.vel_y)
                report($sformatf("agent %0d vel_y %h, want %h", e.agent, d[117:89], e.vel_y));
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;      // agent_id, coord_x, coord_y, seek_on, time_step, pad
    logic [0:0]   s_tuser = '0;      // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;           // out_agent, pos_x, pos_y, vel_x, vel_y, pad
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [3:0]   cfg_index = '0;
    logic [11:0]  cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    agent_table_sb agents = new();

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    seek_steering_kinematics_step_unit dut (.*);

    // receiver stalls decided each falling edge
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) agents.check_result(m_tdata);

    task send_request(logic req, logic [3:0] id, logic [11:0] cx, logic [11:0] cy,
                      logic seek, logic [15:0] dt);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {3'b000, dt, seek, cy, cx, id};
        do @(posedge aclk); while (!s_tready);
        agents.note_request(req, id, cx, cy, seek, dt);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // only used while nothing is in flight
    task write_reg(logic [3:0] idx, logic [11:0] val);
        int n;
        n = 0;
        while (agents.pending.size() != 0 && n < 200000) begin
            @(negedge aclk);
            n++;
        end
        repeat (12) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        agents.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task random_request();
        logic [3:0] id;
        id = 4'($urandom_range(15));
        if ($urandom_range(99) < 8)
            send_request(REQ_PLACE, id, 12'($urandom), 12'($urandom), 1'($urandom),
                         16'($urandom));
        else if ($urandom_range(99) < 80)
            send_request(!REQ_PLACE, id, 12'($urandom), 12'($urandom), 1'b1,
                         ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000)));
        else
            send_request(!REQ_PLACE, id, 12'($urandom), 12'($urandom), 1'b0,
                         16'($urandom));
    endtask

    initial begin
        int wait_cycles;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: extremes, zero distance, no seek, zero speed target
        send_request(!REQ_PLACE, 4'd3, 12'd0, 12'd0, 1'b1, 16'hFFFF);   // zero distance
        send_request(REQ_PLACE, 4'd0, 12'd0, 12'd0, 1'b0, 16'd0);
        send_request(REQ_PLACE, 4'd15, 12'hFFF, 12'hFFF, 1'b1, 16'hFFFF);
        send_request(!REQ_PLACE, 4'd0, 12'hFFF, 12'hFFF, 1'b1, 16'hFFFF);
        send_request(!REQ_PLACE, 4'd0, 12'hFFF, 12'd0, 1'b1, 16'hFFFF);
        send_request(!REQ_PLACE, 4'd15, 12'd0, 12'd0, 1'b1, 16'd0);
        send_request(!REQ_PLACE, 4'd15, 12'd0, 12'd0, 1'b1, 16'hFFFF);
        send_request(!REQ_PLACE, 4'd15, 12'd0, 12'd0, 1'b0, 16'hFFFF);
        // agent 5 placed at the origin, then stepped toward far targets
        send_request(REQ_PLACE, 4'd5, 12'd0, 12'd0, 1'b0, 16'd0);
        send_request(!REQ_PLACE, 4'd5, 12'd0, 12'hFFF, 1'b1, 16'h8000);
        send_request(!REQ_PLACE, 4'd5, 12'hFFF, 12'hFFF, 1'b1, 16'hFFFF);
        send_request(!REQ_PLACE, 4'd5, 12'hFFF, 12'hFFF, 1'b0, 16'hFFFF);
        // zero speed limit: desired velocity change is zero for a resting agent
        write_reg(CFG_SPEED_LIMIT, 12'd0);
        send_request(REQ_PLACE, 4'd7, 12'd100, 12'd100, 1'b0, 16'd0);
        send_request(!REQ_PLACE, 4'd7, 12'd900, 12'd20, 1'b1, 16'hFFFF);
        send_request(!REQ_PLACE, 4'd0, 12'd900, 12'd20, 1'b1, 16'hFFFF);
        write_reg(CFG_SPEED_LIMIT, 12'hFFF);
        write_reg(CFG_ACCEL_LIMIT, 12'hFFF);
        write_reg(CFG_SCREEN_WIDTH, 12'd0);
        write_reg(CFG_SCREEN_HEIGHT, 12'd1);
        send_request(!REQ_PLACE, 4'd15, 12'd0, 12'hFFF, 1'b1, 16'hFFFF);
        send_request(!REQ_PLACE, 4'd15, 12'hFFF, 12'd0, 1'b1, 16'hFFFF);
        send_request(!REQ_PLACE, 4'd15, 12'd0, 12'd0, 1'b0, 16'hFFFF);
        write_reg(4'd9, 12'd55);                                      // unknown index, dropped

        // three idle patterns, three register settings each
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 47 : 0;
            recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 13 : 0;
            for (int set = 0; set < 3; set++) begin
                case ((phase * 3 + set) % 4)
                    0: begin
                        write_reg(CFG_SPEED_LIMIT, 12'hFFF);
                        write_reg(CFG_ACCEL_LIMIT, 12'd0);
                    end
                    1: begin
                        write_reg(CFG_SPEED_LIMIT, 12'd0);
                        write_reg(CFG_ACCEL_LIMIT, 12'hFFF);
                    end
                    default: begin
                        write_reg(CFG_SPEED_LIMIT, 12'($urandom_range(1, 4095)));
                        write_reg(CFG_ACCEL_LIMIT, 12'($urandom_range(1, 4095)));
                    end
                endcase
                case (set)
                    0: begin
                        write_reg(CFG_SCREEN_WIDTH, 12'hFFF);
                        write_reg(CFG_SCREEN_HEIGHT, 12'd0);
                    end
                    1: begin
                        write_reg(CFG_SCREEN_WIDTH, 12'd1);
                        write_reg(CFG_SCREEN_HEIGHT, 12'hFFF);
                    end
                    default: begin
                        write_reg(CFG_SCREEN_WIDTH, 12'($urandom_range(1, 4095)));
                        write_reg(CFG_SCREEN_HEIGHT, 12'($urandom_range(1, 4095)));
                    end
                endcase
                repeat (188) random_request();
            end
        end

        wait_cycles = 0;
        while (agents.pending.size() != 0 && wait_cycles < 200000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (600) @(negedge aclk);
        if (agents.errors == 0 && agents.pending.size() == 0) begin
            $display("tb_seek_steering_kinematics_step_unit passed");
        end else begin
            $display("tb_seek_steering_kinematics_step_unit failed");
        end
        $finish;
    end

    // run limit, well above the slowest correct run
    initial begin
        #200ms;
        $display("tb_seek_steering_kinematics_step_unit failed");
        $finish;
    end
endmodule
